>>> rtl/clt_pkg.sv
// Shared constants, types and helpers for the console line tokenizer.
`default_nettype none

package clt_pkg;

  localparam int TOKEN_SLOTS = 8;
  localparam int TOKEN_CHARS = 16;

  localparam int CT_W  = $clog2(TOKEN_SLOTS + 1);
  localparam int TI_W  = $clog2(TOKEN_SLOTS);
  localparam int LEN_W = $clog2(TOKEN_CHARS + 2);
  localparam int CP_W  = $clog2(TOKEN_CHARS);
  localparam int CA_W  = $clog2(TOKEN_SLOTS * TOKEN_CHARS);

  localparam int TSEL_W = 3;
  localparam int CPOS_W = 4;
  localparam int CNT_W  = 4;
  localparam int RLEN_W = 5;

  localparam logic [7:0] KEY_BACKSPACE = 8'd127;
  localparam logic [7:0] KEY_CTRL_C    = 8'd3;
  localparam logic [7:0] KEY_SPACE     = 8'd32;
  localparam logic [7:0] KEY_CR        = 8'd13;
  localparam logic [7:0] KEY_YES       = 8'd121;
  localparam logic [7:0] KEY_NO        = 8'd110;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_ARM     = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef struct packed {
    logic             clear;
    logic             len_we;
    logic [TI_W-1:0]  len_tok;
    logic [LEN_W-1:0] len_data;
    logic             chr_we;
    logic [CA_W-1:0]  chr_addr;
    logic [7:0]       chr_data;
    logic [TI_W-1:0]  prev_tok;
    logic             rd_en;
    logic [TI_W-1:0]  rd_tok;
    logic [CA_W-1:0]  rd_addr;
  } store_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] rlen;
    logic [7:0]       rchar;
    logic [LEN_W-1:0] prev_len;
  } store_rsp_t;

  typedef struct packed {
    logic              echo;
    logic [7:0]        echo_byte;
    logic              ready;
    logic [CNT_W-1:0]  cnt;
    logic              lerr;
    logic              await;
    logic              conf;
    logic              aerr;
    logic              tsel_ok;
    logic              cpos_ok;
    logic [CPOS_W-1:0] cpos;
  } s1_t;

  function automatic logic [CA_W-1:0] char_addr(input logic [TI_W-1:0] tok,
                                                input logic [CP_W-1:0] pos);
    return CA_W'(CA_W'(tok) * CA_W'(TOKEN_CHARS)) + CA_W'(pos);
  endfunction

endpackage

`default_nettype wire

>>> rtl/clt_store.sv
// Character store and token length store with registered read ports.
`default_nettype none

module clt_store
  import clt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire store_cmd_t cmd,
  output store_rsp_t      rsp
);

  logic [LEN_W-1:0]       len_mem [TOKEN_SLOTS];
  logic [7:0]             chr_mem [TOKEN_SLOTS * TOKEN_CHARS];
  logic [TOKEN_SLOTS-1:0] vld_r;
  logic [LEN_W-1:0]       rlen_r;
  logic [7:0]             rchar_r;
  logic [LEN_W-1:0]       prev_r;

  always_ff @(posedge clk) begin
    if (cmd.len_we) begin
      len_mem[cmd.len_tok] <= cmd.len_data;
    end
    if (cmd.chr_we) begin
      chr_mem[cmd.chr_addr] <= cmd.chr_data;
    end
  end

  // valid bits stand in for clearing the length store
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
    end else if (cmd.len_we) begin
      vld_r[cmd.len_tok] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      if (cmd.clear) begin
        rlen_r <= '0;
      end else if (cmd.len_we && cmd.len_tok == cmd.rd_tok) begin
        rlen_r <= cmd.len_data;
      end else if (vld_r[cmd.rd_tok]) begin
        rlen_r <= len_mem[cmd.rd_tok];
      end else begin
        rlen_r <= '0;
      end
      if (cmd.chr_we && cmd.chr_addr == cmd.rd_addr) begin
        rchar_r <= cmd.chr_data;
      end else begin
        rchar_r <= chr_mem[cmd.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      prev_r <= '0;
    end else if (cmd.len_we && cmd.len_tok == cmd.prev_tok) begin
      prev_r <= cmd.len_data;
    end else if (vld_r[cmd.prev_tok]) begin
      prev_r <= len_mem[cmd.prev_tok];
    end else begin
      prev_r <= '0;
    end
  end

  assign rsp.rlen     = rlen_r;
  assign rsp.rchar    = rchar_r;
  assign rsp.prev_len = prev_r;

endmodule

`default_nettype wire

>>> rtl/console_line_tokenizer.sv
// Top level of the console line tokenizer.
// Takes one item per clock when not stalled: a console byte or a command (arm
// confirmation, release line, read). Each item gives one result via s1 and
// out_data_r, with the line state after that item and the character and length read
// at token_sel and char_pos. Characters sit in a 128-entry store and token lengths
// in an 8-entry store, both with registered reads; the current token's length is
// also held in a register and a second length read port keeps the previous token's
// length at hand, so backspacing into it needs no stall. Ctrl-C (if not ready) and
// release clear the line at once through per-token valid bits; there is no clearing
// pass. A two-deep result path keeps input flowing while a result waits.
`default_nettype none

module console_line_tokenizer
  import clt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // data_byte[7:0], token_sel[10:8], char_pos[14:11]
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // echo_valid[0], echo_byte[8:1], line_ready[9],
                                       // token_count[13:10], length_error[14],
                                       // awaiting_confirm[15], confirmed[16],
                                       // confirm_error[17], read_char[25:18],
                                       // read_length[30:26]
);

  logic                   in_fire;
  mode_t                  mode;
  logic [7:0]             byte_in;
  logic [TSEL_W-1:0]      tsel;
  logic [CPOS_W-1:0]      cpos;
  logic                   tsel_ok;
  logic                   cpos_ok;

  logic [CT_W-1:0]        ct_r, ct_nxt;
  logic [LEN_W-1:0]       cur_len_r, cur_len_nxt;
  logic                   ready_r, ready_nxt;
  logic                   await_r, await_nxt;
  logic                   conf_r, conf_nxt;
  logic                   aerr_r, aerr_nxt;
  logic [TOKEN_SLOTS-1:0] ovf_r, ovf_nxt;
  logic                   lerr_nxt;
  logic                   clr;
  logic                   echo;
  logic                   len_wr;
  logic                   in_range;
  logic [TI_W-1:0]        cur_tok;
  logic [TI_W-1:0]        rd_tok;

  store_cmd_t             cmd;
  store_rsp_t             rsp;

  logic                   s1_vld_r;
  s1_t                    s1_r, s1_nxt;
  logic                   s1_adv;
  logic                   out_vld_r;
  logic [31:0]            out_data_r, out_nxt;
  logic [RLEN_W-1:0]      rlen_o;
  logic [7:0]             rchar_o;

  assign mode     = mode_t'(in_tuser);
  assign byte_in  = in_tdata[7:0];
  assign tsel     = in_tdata[10:8];
  assign cpos     = in_tdata[14:11];
  assign tsel_ok  = 32'(tsel) < TOKEN_SLOTS;
  assign cpos_ok  = 32'(cpos) < TOKEN_CHARS;
  assign in_fire  = in_tvalid && in_tready;
  assign in_range = ct_r < CT_W'(TOKEN_SLOTS);
  assign cur_tok  = TI_W'(ct_r);
  assign rd_tok   = tsel_ok ? TI_W'(tsel) : '0;

  clt_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  always_comb begin
    ct_nxt      = ct_r;
    cur_len_nxt = cur_len_r;
    ready_nxt   = ready_r;
    await_nxt   = await_r;
    conf_nxt    = conf_r;
    aerr_nxt    = aerr_r;
    ovf_nxt     = ovf_r;
    clr         = 1'b0;
    echo        = 1'b0;
    len_wr      = 1'b0;
    cmd         = '0;
    cmd.rd_en   = in_fire;
    cmd.rd_tok  = rd_tok;
    cmd.rd_addr = char_addr(rd_tok, cpos_ok ? CP_W'(cpos) : '0);
    if (in_fire) begin
      unique case (mode)
        MODE_BYTE: begin
          if (!ready_r) begin
            if (byte_in == KEY_CTRL_C) begin
              clr = 1'b1;
            end else begin
              echo = 1'b1;
              case (byte_in)
                KEY_BACKSPACE: begin
                  if (in_range && cur_len_r != '0) begin
                    cur_len_nxt = cur_len_r - 1'b1;
                    len_wr      = 1'b1;
                  end else if (ct_r != '0) begin
                    ct_nxt      = ct_r - 1'b1;
                    cur_len_nxt = rsp.prev_len;
                  end
                end
                KEY_SPACE: begin
                  if (in_range) begin
                    ct_nxt      = ct_r + 1'b1;
                    cur_len_nxt = '0;
                  end
                end
                KEY_CR: begin
                  ready_nxt = 1'b1;
                end
                default: begin
                  if (in_range) begin
                    if (cur_len_r < LEN_W'(TOKEN_CHARS)) begin
                      cmd.chr_we   = 1'b1;
                      cmd.chr_addr = char_addr(cur_tok, CP_W'(cur_len_r));
                      cmd.chr_data = byte_in;
                    end
                    if (cur_len_r <= LEN_W'(TOKEN_CHARS)) begin
                      cur_len_nxt = cur_len_r + 1'b1;
                      len_wr      = 1'b1;
                    end
                  end
                end
              endcase
            end
          end else if (await_r) begin
            echo = 1'b1;
            case (byte_in)
              KEY_YES: begin
                conf_nxt = 1'b1;
              end
              KEY_NO: begin
                conf_nxt = 1'b0;
              end
              default: begin
                aerr_nxt = 1'b1;
              end
            endcase
            await_nxt = 1'b0;
          end
        end
        MODE_ARM: begin
          aerr_nxt  = 1'b0;
          await_nxt = 1'b1;
        end
        MODE_RELEASE: begin
          clr = 1'b1;
        end
        MODE_READ: begin
        end
        default: begin
        end
      endcase
    end
    if (len_wr) begin
      cmd.len_we        = 1'b1;
      cmd.len_tok       = cur_tok;
      cmd.len_data      = cur_len_nxt;
      ovf_nxt[cur_tok]  = cur_len_nxt > LEN_W'(TOKEN_CHARS);
    end
    if (clr) begin
      ct_nxt      = '0;
      cur_len_nxt = '0;
      ready_nxt   = 1'b0;
      await_nxt   = 1'b0;
      conf_nxt    = 1'b0;
      aerr_nxt    = 1'b0;
      ovf_nxt     = '0;
      cmd.clear   = 1'b1;
    end
    cmd.prev_tok = (ct_nxt == '0) ? '0 : TI_W'(ct_nxt - 1'b1);
    lerr_nxt     = (ct_nxt >= CT_W'(TOKEN_SLOTS)) || (|ovf_nxt);

    s1_nxt.echo      = echo;
    s1_nxt.echo_byte = echo ? byte_in : '0;
    s1_nxt.ready     = ready_nxt;
    s1_nxt.cnt       = CNT_W'(ct_nxt);
    s1_nxt.lerr      = lerr_nxt;
    s1_nxt.await     = await_nxt;
    s1_nxt.conf      = conf_nxt;
    s1_nxt.aerr      = aerr_nxt;
    s1_nxt.tsel_ok   = tsel_ok;
    s1_nxt.cpos_ok   = cpos_ok;
    s1_nxt.cpos      = cpos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ct_r      <= '0;
      cur_len_r <= '0;
      ready_r   <= 1'b0;
      await_r   <= 1'b0;
      conf_r    <= 1'b0;
      aerr_r    <= 1'b0;
      ovf_r     <= '0;
    end else begin
      ct_r      <= ct_nxt;
      cur_len_r <= cur_len_nxt;
      ready_r   <= ready_nxt;
      await_r   <= await_nxt;
      conf_r    <= conf_nxt;
      aerr_r    <= aerr_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // store read data lands in the cycle after acceptance, alongside s1
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;

  always_comb begin
    rlen_o  = s1_r.tsel_ok ? RLEN_W'(rsp.rlen) : '0;
    rchar_o = (s1_r.tsel_ok && s1_r.cpos_ok && (32'(s1_r.cpos) < 32'(rsp.rlen))) ?
              rsp.rchar : '0;
    out_nxt = {1'b0, rlen_o, rchar_o, s1_r.aerr, s1_r.conf, s1_r.await, s1_r.lerr,
               s1_r.cnt, s1_r.ready, s1_r.echo_byte, s1_r.echo};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_ct_range: assert property (@(posedge clk) disable iff (!rst_n)
    ct_r <= CT_W'(TOKEN_SLOTS))
    else $error("token index beyond overflow slot");

  a_ovf_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ct_r == CT_W'(TOKEN_SLOTS)) |-> (cur_len_r == '0))
    else $error("overflow slot holds a length");

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cur_len_r <= LEN_W'(TOKEN_CHARS + 1))
    else $error("token length beyond saturation");

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> ($stable(rsp.rlen) && $stable(rsp.rchar)))
    else $error("store read data lost while stage stalled");

  a_s1_room: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("input blocked with empty stage");
`endif

endmodule

`default_nettype wire
